### sv/bdd_pkg.sv
package bdd_pkg;

	// Default dictionary depth.
	localparam int DICT_ENTRIES_DEF = 256;

	// Widths of the result fields.
	localparam int INDEX_W = 8;
	localparam int USED_W  = 9;

	// One input item: a block of eight bytes, first byte in the low bits.
	typedef struct packed {
		logic [63:0] block_bytes;
		logic        last_block;
	} bdd_in_t;

	// One result item.
	typedef struct packed {
		logic [INDEX_W-1:0] block_index;
		logic               new_entry;
		logic               table_full;
		logic [USED_W-1:0]  entries_used;
	} bdd_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic hit_done;
		logic miss_done;
	} bdd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic match;
		logic cmp_last;
	} bdd_sts_t;

endpackage

### sv/bdd_datapath.sv
module bdd_datapath
	import bdd_pkg::*;
#(
	parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  bdd_in_t  item,
	input  bdd_cmd_t cmd,
	output bdd_sts_t sts,
	output logic     done,
	output bdd_out_t result
);

	localparam int AW = $clog2(DICT_ENTRIES);
	localparam int CW = $clog2(DICT_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DICT_ENTRIES);

	// Dictionary memory; entries at and above the fill count are never read.
	logic [63:0] mem [DICT_ENTRIES];
	logic [63:0] rd_data_q;

	logic [63:0]   block_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] cmp_idx_q;
	logic          cmp_valid_q;
	logic          done_q;
	bdd_out_t      result_q;

	logic          full;
	logic          issue;
	logic          wr_en;
	logic [CW-1:0] count_inc;
	logic [CW+INDEX_W-1:0] cmp_idx_wide;
	logic [CW+INDEX_W-1:0] count_idx_wide;
	logic [CW+USED_W-1:0]  count_used_wide;
	logic [CW+USED_W-1:0]  inc_used_wide;

	assign full      = (count_q == FULL_COUNT);
	assign issue     = cmd.scan && (rd_idx_q != count_q);
	assign wr_en     = cmd.miss_done && !full;
	assign count_inc = count_q + 1'b1;

	// Widen, then take the low bits, so the result fields fit any depth.
	assign cmp_idx_wide    = {{INDEX_W{1'b0}}, cmp_idx_q};
	assign count_idx_wide  = {{INDEX_W{1'b0}}, count_q};
	assign count_used_wide = {{USED_W{1'b0}}, count_q};
	assign inc_used_wide   = {{USED_W{1'b0}}, count_inc};

	// Status towards the controller.
	assign sts.empty    = (count_q == '0);
	assign sts.match    = cmp_valid_q && (rd_data_q == block_q);
	assign sts.cmp_last = cmp_valid_q && (CW'(cmp_idx_q + 1'b1) == count_q);

	// Memory: one write port for appends, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= block_q;
		end
		if (issue) begin
			rd_data_q <= mem[rd_idx_q[AW-1:0]];
		end
	end

	// Latched item and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			block_q <= item.block_bytes;
			last_q  <= item.last_block;
		end
		if (cmd.hit_done) begin
			result_q.block_index  <= cmp_idx_wide[INDEX_W-1:0];
			result_q.new_entry    <= 1'b0;
			result_q.table_full   <= 1'b0;
			result_q.entries_used <= count_used_wide[USED_W-1:0];
		end else if (cmd.miss_done) begin
			if (full) begin
				result_q.block_index  <= '0;
				result_q.new_entry    <= 1'b0;
				result_q.table_full   <= 1'b1;
				result_q.entries_used <= count_used_wide[USED_W-1:0];
			end else begin
				result_q.block_index  <= count_idx_wide[INDEX_W-1:0];
				result_q.new_entry    <= 1'b1;
				result_q.table_full   <= 1'b0;
				result_q.entries_used <= inc_used_wide[USED_W-1:0];
			end
		end
	end

	// Scan pointers, fill count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_idx_q    <= '0;
			cmp_idx_q   <= '0;
			cmp_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.hit_done || cmd.miss_done;
			if (cmd.load) begin
				rd_idx_q    <= '0;
				cmp_valid_q <= 1'b0;
			end else if (issue) begin
				rd_idx_q    <= rd_idx_q + 1'b1;
				cmp_idx_q   <= rd_idx_q;
				cmp_valid_q <= 1'b1;
			end else begin
				cmp_valid_q <= 1'b0;
			end
			if ((cmd.hit_done || cmd.miss_done) && last_q) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_inc;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// The fill count never passes the dictionary depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_COUNT)
		else $error("fill count beyond dictionary depth");

	// A result is never both a new entry and a full-table miss.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(result_q.new_entry && result_q.table_full))
		else $error("new entry and table full together");

	// A compare only ever looks at an entry below the fill count.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid_q |-> (cmp_idx_q < count_q))
		else $error("compare beyond filled entries");

endmodule

### sv/bdd_ctrl.sv
module bdd_ctrl
	import bdd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  bdd_sts_t sts,
	output bdd_cmd_t cmd,
	output logic     busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.scan      = 1'b0;
		cmd.hit_done  = 1'b0;
		cmd.miss_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.match) begin
					cmd.hit_done = 1'b1;
					state_d      = ST_IDLE;
				end else if (sts.cmp_last || sts.empty) begin
					cmd.miss_done = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Hit and miss never finish the same item together.
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.hit_done && cmd.miss_done))
		else $error("hit and miss in the same cycle");

endmodule

### sv/block_dedup_dictionary_unit.sv
// A hit gives its result once the scan reaches the matching entry; a miss first scans every
// filled entry, and on an empty dictionary gives its result without reading memory.
// One item at a time; the scan reads one dictionary entry per cycle
// from a single registered memory read port.
// Reset clears the fill count and the controller; dictionary contents are not cleared.
// Each result shows for one cycle on done; the receiver cannot stall it.
module block_dedup_dictionary_unit
	import bdd_pkg::*;
#(
	parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  bdd_in_t  item,
	output logic     done,
	output bdd_out_t result
);

	bdd_cmd_t cmd;
	bdd_sts_t sts;

	// Sequencer for the scan of one item.
	bdd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Dictionary memory, fill count and result register.
	bdd_datapath #(
		.DICT_ENTRIES (DICT_ENTRIES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

	// The item's result appears as soon as the unit frees up.
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> done)
		else $error("unit went idle without a result");

endmodule

### verif/bdd_checker.sv
`timescale 1ns / 100ps

// Watches the command and result channels of the deduplication dictionary,
// predicts each result from its own copy of the dictionary and compares.
module bdd_checker
	import bdd_pkg::*;
#(
	parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  bdd_in_t  item,
	input  logic     done,
	input  bdd_out_t result,
	output int       errors,
	output int       pending,
	output int       hits,
	output int       appended,
	output int       full_misses,
	output int       tables
);

	// Predicted dictionary contents and fill level.
	logic [63:0] dict_words [DICT_ENTRIES];
	int unsigned fill_count;

	// Results still owed by the block, oldest first.
	bdd_out_t    owed_results [$];

	// Searches the predicted dictionary for one block, appends it on a miss
	// and returns the result the block should give.
	function automatic bdd_out_t lookup_block(input bdd_in_t blk);
		bdd_out_t    r;
		bit          found;
		int unsigned k;
		r = '0;
		found = 1'b0;
		for (k = 0; k < fill_count; k++) begin
			if (!found && dict_words[k] == blk.block_bytes) begin
				r.block_index = INDEX_W'(k);
				found = 1'b1;
			end
		end
		if (!found) begin
			if (fill_count < DICT_ENTRIES) begin
				dict_words[fill_count] = blk.block_bytes;
				r.block_index = INDEX_W'(fill_count);
				fill_count++;
				r.new_entry = 1'b1;
			end else begin
				r.table_full = 1'b1;
			end
		end
		r.entries_used = USED_W'(fill_count);
		// The last block of a table empties the dictionary once handled.
		if (blk.last_block)
			fill_count = 0;
		return r;
	endfunction

	assign pending = owed_results.size();

	// Results are compared before the item of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		bdd_out_t want;
		if (!arst_n) begin
			fill_count = 0;
			owed_results.delete();
			errors = 0;
			hits = 0;
			appended = 0;
			full_misses = 0;
			tables = 0;
		end else begin
			if (done) begin
				if (owed_results.size() == 0) begin
					$error("result with no item outstanding: index %0d", result.block_index);
					errors++;
				end else begin
					want = owed_results.pop_front();
					if (result.block_index !== want.block_index) begin
						$error("block_index: expected %0d, got %0d",
							want.block_index, result.block_index);
						errors++;
					end
					if (result.new_entry !== want.new_entry) begin
						$error("new_entry: expected %0d, got %0d",
							want.new_entry, result.new_entry);
						errors++;
					end
					if (result.table_full !== want.table_full) begin
						$error("table_full: expected %0d, got %0d",
							want.table_full, result.table_full);
						errors++;
					end
					if (result.entries_used !== want.entries_used) begin
						$error("entries_used: expected %0d, got %0d",
							want.entries_used, result.entries_used);
						errors++;
					end
					if (want.table_full)
						full_misses++;
					else if (want.new_entry)
						appended++;
					else
						hits++;
				end
			end
			if (start && !busy) begin
				owed_results.push_back(lookup_block(item));
				if (item.last_block)
					tables++;
			end
		end
	end

endmodule

### verif/tb_block_dedup_dictionary_unit.sv
`timescale 1ns / 100ps

module tb_block_dedup_dictionary_unit;
	import bdd_pkg::*;

	localparam int DEPTH       = DICT_ENTRIES_DEF;
	localparam int TARGET      = 1850;
	localparam int DRAIN_LIMIT = 100000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	bdd_in_t  item;
	logic     done;
	bdd_out_t result;

	int errors, pending, hits, appended, full_misses, tables;

	int          issued;
	int          idle_pct;
	int          drain_cycles;
	logic [63:0] table_blocks [$];

	block_dedup_dictionary_unit #(.DICT_ENTRIES(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	bdd_checker #(.DICT_ENTRIES(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.errors      (errors),
		.pending     (pending),
		.hits        (hits),
		.appended    (appended),
		.full_misses (full_misses),
		.tables      (tables)
	);

	// Free-running clock, 20 ns period.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#50_000_000;
		$display("FAILURE");
		$finish;
	end

	// Offers one block after a random gap and returns once it is accepted.
	// Start is left high so that a following item can go without a gap.
	task automatic issue_block(input logic [63:0] blk_word, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		item.block_bytes <= blk_word;
		item.last_block <= last;
		do @(posedge clk); while (busy);
		issued++;
		if (last)
			table_blocks.delete();
		else
			table_blocks.push_back(blk_word);
	endtask

	// Picks a block for the random part: a fresh word, a word already in
	// the table, or a stored word with one bit set to the inverse of a random bit.
	function automatic logic [63:0] pick_block(input bit mostly_fresh);
		int          r;
		logic [63:0] w;
		r = $urandom_range(0, 99);
		if (table_blocks.size() == 0 || r < (mostly_fresh ? 85 : 40))
			return {$urandom, $urandom};
		w = table_blocks[$urandom_range(0, table_blocks.size() - 1)];
		if (r < (mostly_fresh ? 90 : 55))
			w[$urandom_range(0, 63)] = ~w[$urandom_range(0, 63)];
		return w;
	endfunction

	initial begin
		int tbl;
		int len;
		int j;
		bit fill;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		issued = 0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme words, hits, single-bit differences, and the last
		// block both on a filled and on an empty dictionary.
		issue_block(64'h0, 1'b0);
		issue_block(64'h0, 1'b0);
		issue_block('1, 1'b0);
		issue_block('1, 1'b0);
		issue_block(64'h5555_5555_5555_5555, 1'b0);
		issue_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		issue_block(64'h0000_0000_0000_0001, 1'b0);
		issue_block(64'h8000_0000_0000_0000, 1'b0);
		issue_block(64'h5555_5555_5555_5555, 1'b0);
		issue_block(64'h0, 1'b1);
		// Stale words left behind by the clear must not be matched.
		issue_block('1, 1'b0);
		issue_block('1, 1'b1);
		issue_block({$urandom, $urandom}, 1'b1);
		issue_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		issue_block(64'h8000_0000_0000_0000, 1'b1);

		// Random tables; every fourth one is longer than the dictionary depth.
		tbl = 0;
		while (issued < TARGET) begin
			fill = (tbl % 4 == 1);
			len = fill ? DEPTH + $urandom_range(4, 30) : $urandom_range(1, 48);
			for (j = 0; j < len; j++) begin
				case ((issued / 150) % 3)
					0: idle_pct = 0;
					1: idle_pct = 87;
					default: idle_pct = 36;
				endcase
				issue_block(pick_block(fill && j < DEPTH), j == len - 1);
			end
			tbl++;
		end
		@(negedge clk);
		start <= 1'b0;

		// Drain, then allow for a full scan in case anything else turns up.
		drain_cycles = 0;
		while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_cycles++;
		end
		repeat (DEPTH + 8) @(negedge clk);

		$display("Ran %0d blocks in %0d tables: %0d hits, %0d appended, %0d full misses.",
			issued, tables, hits, appended, full_misses);
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results never arrived.", errors, pending);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
